// ===== rtl/dtd_pkg.sv =====
// ----------------------------------------------------------------------------
// dtd_pkg
// shared types, codes and the fragment rom for the dictionary text decompressor
// ----------------------------------------------------------------------------
package dtd_pkg;

  localparam int unsigned DictEntries = 219;
  localparam int unsigned MaxFragLen  = 8;
  localparam int unsigned LenBits     = 16;
  localparam int unsigned FragLenBits = $clog2(MaxFragLen + 1);
  localparam int unsigned FragIdxBits = $clog2(MaxFragLen);

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StTruncated = 3'd1;
  localparam logic [2:0] StZeroRun   = 3'd2;
  localparam logic [2:0] StRunPast   = 3'd3;
  localparam logic [2:0] StOverCap   = 3'd4;
  localparam logic [2:0] StBadIndex  = 3'd5;

  localparam logic [1:0] ModeCode  = 2'd0;
  localparam logic [1:0] ModeLit1  = 2'd1;
  localparam logic [1:0] ModeCount = 2'd2;
  localparam logic [1:0] ModeRun   = 2'd3;

  localparam logic [1:0] CfgSingle   = 2'd0;
  localparam logic [1:0] CfgRun      = 2'd1;
  localparam logic [1:0] CfgCapacity = 2'd2;

  // job handed from front to back: either one literal byte, a fragment, or a report
  typedef struct packed {
    logic                   is_report;
    logic                   is_frag;
    logic [7:0]             data;      // literal byte or fragment index
    logic [FragLenBits-1:0] frag_len;
    logic                   last;      // final job of this input word
    logic [2:0]             status;
    logic [LenBits-1:0]     length;
  } job_t;

  function automatic logic [63:0] frag_word(input logic [7:0] idx);
    logic [63:0] s;
    s = 64'd0;
    case (idx)
      8'd0: s = " the "; 8'd1: s = "the "; 8'd2: s = "and "; 8'd3: s = "ing ";
      8'd4: s = "ion "; 8'd5: s = " to "; 8'd6: s = "tion"; 8'd7: s = "that";
      8'd8: s = "here"; 8'd9: s = "with"; 8'd10: s = "have"; 8'd11: s = "this";
      8'd12: s = "from"; 8'd13: s = "your"; 8'd14: s = " at "; 8'd15: s = " on ";
      8'd16: s = " in "; 8'd17: s = " is "; 8'd18: s = " of "; 8'd19: s = " we ";
      8'd20: s = " be "; 8'd21: s = " it "; 8'd22: s = " no "; 8'd23: s = " ok";
      8'd24: s = "over"; 8'd25: s = "copy"; 8'd26: s = "roger"; 8'd27: s = "north";
      8'd28: s = "south"; 8'd29: s = "east"; 8'd30: s = "west"; 8'd31: s = "position";
      8'd32: s = "status"; 8'd33: s = "moving"; 8'd34: s = "arrived";
      8'd35: s = "standby"; 8'd36: s = "confirm"; 8'd37: s = "negative";
      8'd38: s = "affirm"; 8'd39: s = "repeat"; 8'd40: s = "message";
      8'd41: s = "contact"; 8'd42: s = "location"; 8'd43: s = "battery";
      8'd44: s = "signal"; 8'd45: s = "return"; 8'd46: s = "base"; 8'd47: s = "camp";
      8'd48: s = "road"; 8'd49: s = "river"; 8'd50: s = "bridge"; 8'd51: s = "hill";
      8'd52: s = "ridge"; 8'd53: s = "valley"; 8'd54: s = "point"; 8'd55: s = "meet";
      8'd56: s = "need"; 8'd57: s = "help"; 8'd58: s = "come"; 8'd59: s = "back";
      8'd60: s = "went"; 8'd61: s = "will"; 8'd62: s = "wait"; 8'd63: s = "hold";
      8'd64: s = "move"; 8'd65: s = "stop"; 8'd66: s = "left"; 8'd67: s = "right";
      8'd68: s = "up"; 8'd69: s = "down"; 8'd70: s = "now"; 8'd71: s = "min";
      8'd72: s = "hour"; 8'd73: s = "day"; 8'd74: s = "km"; 8'd75: s = "get";
      8'd76: s = "got"; 8'd77: s = "can"; 8'd78: s = "not"; 8'd79: s = "you";
      8'd80: s = "are"; 8'd81: s = "for"; 8'd82: s = "was"; 8'd83: s = "all";
      8'd84: s = "out"; 8'd85: s = "see"; 8'd86: s = "way"; 8'd87: s = "who";
      8'd88: s = "how"; 8'd89: s = "why"; 8'd90: s = "yes"; 8'd91: s = "has";
      8'd92: s = "man"; 8'd93: s = "new"; 8'd94: s = "old"; 8'd95: s = "one";
      8'd96: s = "two"; 8'd97: s = "ten"; 8'd98: s = "map"; 8'd99: s = "gps";
      8'd100: s = "sos"; 8'd101: s = "eta"; 8'd102: s = "the"; 8'd103: s = "and";
      8'd104: s = "ent"; 8'd105: s = "ers"; 8'd106: s = "ess"; 8'd107: s = "est";
      8'd108: s = "ate"; 8'd109: s = "ter"; 8'd110: s = "ver"; 8'd111: s = "ist";
      8'd112: s = "ain"; 8'd113: s = "ome"; 8'd114: s = "our"; 8'd115: s = "ould";
      8'd116: s = "ough"; 8'd117: s = "ight"; 8'd118: s = "tch"; 8'd119: s = "sh";
      8'd120: s = "ch"; 8'd121: s = "th"; 8'd122: s = "wh"; 8'd123: s = "qu";
      8'd124: s = "ck"; 8'd125: s = "ng"; 8'd126: s = "st"; 8'd127: s = "nd";
      8'd128: s = "rd"; 8'd129: s = "ll"; 8'd130: s = "ss"; 8'd131: s = "ee";
      8'd132: s = "oo"; 8'd133: s = "ea"; 8'd134: s = "ou"; 8'd135: s = "ai";
      8'd136: s = "ie"; 8'd137: s = "er"; 8'd138: s = "re"; 8'd139: s = "an";
      8'd140: s = "in"; 8'd141: s = "on"; 8'd142: s = "at"; 8'd143: s = "en";
      8'd144: s = "es"; 8'd145: s = "or"; 8'd146: s = "ar"; 8'd147: s = "it";
      8'd148: s = "is"; 8'd149: s = "to"; 8'd150: s = "of"; 8'd151: s = "as";
      8'd152: s = "be"; 8'd153: s = "by"; 8'd154: s = "he"; 8'd155: s = "we";
      8'd156: s = "do"; 8'd157: s = "go"; 8'd158: s = "no"; 8'd159: s = "so";
      8'd160: s = "us"; 8'd161: s = "me"; 8'd162: s = "my"; 8'd163: s = "if";
      8'd164: s = "am"; 8'd165: s = "e "; 8'd166: s = "t "; 8'd167: s = "a ";
      8'd168: s = "o "; 8'd169: s = "i "; 8'd170: s = "n "; 8'd171: s = "s ";
      8'd172: s = "r "; 8'd173: s = "d "; 8'd174: s = "l "; 8'd175: s = ". ";
      8'd176: s = ", "; 8'd177: s = "! "; 8'd178: s = "? "; 8'd179: s = "; ";
      8'd180: s = ": "; 8'd181: s = " "; 8'd182: s = "e"; 8'd183: s = "t";
      8'd184: s = "a"; 8'd185: s = "o"; 8'd186: s = "i"; 8'd187: s = "n";
      8'd188: s = "s"; 8'd189: s = "r"; 8'd190: s = "h"; 8'd191: s = "l";
      8'd192: s = "d"; 8'd193: s = "c"; 8'd194: s = "u"; 8'd195: s = "m";
      8'd196: s = "f"; 8'd197: s = "p"; 8'd198: s = "g"; 8'd199: s = "w";
      8'd200: s = "y"; 8'd201: s = "b"; 8'd202: s = "v"; 8'd203: s = "k";
      8'd204: s = "0"; 8'd205: s = "1"; 8'd206: s = "2"; 8'd207: s = "3";
      8'd208: s = "4"; 8'd209: s = "5"; 8'd210: s = "6"; 8'd211: s = "7";
      8'd212: s = "8"; 8'd213: s = "9"; 8'd214: s = "."; 8'd215: s = ",";
      8'd216: s = "-"; 8'd217: s = "/"; 8'd218: s = "'";
      default: s = 64'd0;
    endcase
    return s;
  endfunction

  // string literal is right-aligned: count nonzero bytes, first char is the highest one
  function automatic logic [FragLenBits-1:0] frag_len(input logic [7:0] idx);
    logic [63:0]            w;
    logic [FragLenBits-1:0] n;
    w = frag_word(idx);
    n = '0;
    for (int i = 0; i < MaxFragLen; i++) begin
      if (w[8*i +: 8] != 8'd0) n = FragLenBits'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [7:0] frag_char(input logic [7:0] idx,
                                           input logic [FragLenBits-1:0] len,
                                           input logic [FragIdxBits-1:0] pos);
    logic [63:0] w;
    logic [FragLenBits:0] sel;
    w = frag_word(idx);
    sel = {1'b0, len} - {1'b0, FragLenBits'(pos)} - {{FragLenBits{1'b0}}, 1'b1};
    return w[8*sel[FragIdxBits-1:0] +: 8];
  endfunction

endpackage

// ===== rtl/dtd_front.sv =====
// ----------------------------------------------------------------------------
// dtd_front
// classifies code bytes, tracks message state and length, issues jobs
// ----------------------------------------------------------------------------
module dtd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [15:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  code_byte_i,
  input  logic                        message_end_i,
  output logic                        job0_valid_o,
  output dtd_pkg::job_t               job0_o,
  output logic                        job1_valid_o,
  output dtd_pkg::job_t               job1_o,
  input  logic                        q_room2_i
);

  logic [7:0]                   single_q, run_q;
  logic [15:0]                  cap_q;
  logic [1:0]                   mode_q, mode_d;
  logic [7:0]                   rem_q, rem_d;
  logic [dtd_pkg::LenBits-1:0]  cnt_q, cnt_d;
  logic [2:0]                   err_q, err_d;
  logic                         fire;
  logic [dtd_pkg::FragLenBits-1:0] flen;
  logic [16:0]                  need;
  logic                         fits;
  logic                         emit;
  dtd_pkg::job_t                data_job, rep_job;
  logic [2:0]                   st;

  assign in_ready_o = q_room2_i;
  assign fire       = in_valid_i && in_ready_o;
  assign flen       = dtd_pkg::frag_len(code_byte_i);

  always_comb begin
    need = 17'(cnt_q) + 17'd1;
    if (mode_q == dtd_pkg::ModeCount) need = 17'(cnt_q) + 17'(code_byte_i);
    else if (mode_q == dtd_pkg::ModeCode) need = 17'(cnt_q) + 17'(flen);
  end
  assign fits = need <= 17'(cap_q);

  always_comb begin
    mode_d = mode_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    err_d  = err_q;
    emit   = 1'b0;
    data_job = '0;
    if (err_q == dtd_pkg::StOk) begin
      unique case (mode_q)
        dtd_pkg::ModeLit1: begin
          if (fits) begin
            emit = 1'b1;
            cnt_d = cnt_q + dtd_pkg::LenBits'(1);
            mode_d = dtd_pkg::ModeCode;
          end else begin
            err_d = dtd_pkg::StOverCap;
          end
        end
        dtd_pkg::ModeCount: begin
          if (code_byte_i == 8'd0) err_d = dtd_pkg::StZeroRun;
          else if (!fits) err_d = dtd_pkg::StOverCap;
          else begin
            rem_d = code_byte_i;
            mode_d = dtd_pkg::ModeRun;
          end
        end
        dtd_pkg::ModeRun: begin
          emit = 1'b1;
          cnt_d = cnt_q + dtd_pkg::LenBits'(1);
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) mode_d = dtd_pkg::ModeCode;
        end
        default: begin
          if (code_byte_i == single_q) mode_d = dtd_pkg::ModeLit1;
          else if (code_byte_i == run_q) mode_d = dtd_pkg::ModeCount;
          else if (32'(code_byte_i) >= dtd_pkg::DictEntries) err_d = dtd_pkg::StBadIndex;
          else if (fits) begin
            emit = 1'b1;
            data_job.is_frag = 1'b1;
            cnt_d = cnt_q + dtd_pkg::LenBits'(flen);
          end else begin
            err_d = dtd_pkg::StOverCap;
          end
        end
      endcase
    end
    data_job.data     = code_byte_i;
    data_job.frag_len = flen;
    data_job.last     = !message_end_i;

    st = err_d;
    if (st == dtd_pkg::StOk) begin
      if (mode_d == dtd_pkg::ModeLit1 || mode_d == dtd_pkg::ModeCount)
        st = dtd_pkg::StTruncated;
      else if (mode_d == dtd_pkg::ModeRun) st = dtd_pkg::StRunPast;
    end
    rep_job = '0;
    rep_job.is_report = 1'b1;
    rep_job.last      = 1'b1;
    rep_job.status    = st;
    rep_job.length    = cnt_d;
  end

  // report goes in second slot when a data job exists, else in the first
  always_comb begin
    job0_valid_o = fire && (emit || message_end_i);
    job0_o       = emit ? data_job : rep_job;
    job1_valid_o = fire && emit && message_end_i;
    job1_o       = rep_job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_q <= 8'd254;
      run_q    <= 8'd255;
      cap_q    <= 16'd255;
      mode_q   <= dtd_pkg::ModeCode;
      rem_q    <= '0;
      cnt_q    <= '0;
      err_q    <= dtd_pkg::StOk;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dtd_pkg::CfgSingle:   single_q <= cfg_data_i[7:0];
          dtd_pkg::CfgRun:      run_q    <= cfg_data_i[7:0];
          dtd_pkg::CfgCapacity: cap_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (fire) begin
        if (message_end_i) begin
          mode_q <= dtd_pkg::ModeCode;
          rem_q  <= '0;
          cnt_q  <= '0;
          err_q  <= dtd_pkg::StOk;
        end else begin
          mode_q <= mode_d;
          rem_q  <= rem_d;
          cnt_q  <= cnt_d;
          err_q  <= err_d;
        end
      end
    end
  end

endmodule

// ===== rtl/dtd_queue.sv =====
// ----------------------------------------------------------------------------
// dtd_queue
// four-entry job fifo, takes up to two jobs per cycle, hands out one
// ----------------------------------------------------------------------------
module dtd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr0_i,
  input  dtd_pkg::job_t  wd0_i,
  input  logic           wr1_i,
  input  dtd_pkg::job_t  wd1_i,
  output logic           room2_o,
  output logic           rd_valid_o,
  output dtd_pkg::job_t  rd_data_o,
  input  logic           rd_i
);

  dtd_pkg::job_t mem_q [4];
  logic [1:0]    wp_q, rp_q;
  logic [2:0]    cnt_q;
  logic          pop;
  logic [1:0]    nwr;

  assign rd_valid_o = cnt_q != 3'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign pop        = rd_i && rd_valid_o;
  assign room2_o    = cnt_q <= 3'd2;
  assign nwr        = 2'(wr0_i) + 2'(wr1_i);

  always_ff @(posedge clk_i) begin
    if (wr0_i) mem_q[wp_q] <= wd0_i;
    if (wr1_i) mem_q[wp_q + 2'd1] <= wd1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + nwr;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_q + 3'(nwr) - 3'(pop);
    end
  end

endmodule

// ===== rtl/dtd_back.sv =====
// ----------------------------------------------------------------------------
// dtd_back
// expands jobs into output words, one byte per cycle unless stalled, with output register
// ----------------------------------------------------------------------------
module dtd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  dtd_pkg::job_t  job_i,
  output logic           job_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     text_byte_o,
  output logic           item_kind_o,
  output logic           run_last_o,
  output logic [2:0]     status_o,
  output logic [15:0]    total_length_o
);

  logic [dtd_pkg::FragIdxBits-1:0] pos_q;
  logic                            ov_q;
  logic                            load;
  logic                            final_byte;

  assign load = !ov_q || out_ready_i;
  assign final_byte = !job_i.is_frag || job_i.is_report ||
                      (dtd_pkg::FragLenBits'(pos_q) + dtd_pkg::FragLenBits'(1) ==
                       job_i.frag_len);
  assign job_pop_o = load && job_valid_i && final_byte;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i) begin
    if (load && job_valid_i) begin
      item_kind_o    <= job_i.is_report;
      text_byte_o    <= job_i.is_report ? 8'd0 :
                        job_i.is_frag ? dtd_pkg::frag_char(job_i.data, job_i.frag_len, pos_q)
                                      : job_i.data;
      // the data job of a word with a report has last cleared
      run_last_o     <= final_byte && job_i.last;
      status_o       <= job_i.is_report ? job_i.status : 3'd0;
      total_length_o <= job_i.is_report ? job_i.length : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      pos_q <= '0;
    end else if (load) begin
      ov_q <= job_valid_i;
      if (job_valid_i) pos_q <= final_byte ? '0 : pos_q + dtd_pkg::FragIdxBits'(1);
    end
  end

endmodule

// ===== rtl/dictionary_text_decompressor_top.sv =====
// ----------------------------------------------------------------------------
// dictionary_text_decompressor_top
// static-dictionary text decompressor with per-message status report
// ----------------------------------------------------------------------------
// A code byte is accepted every cycle while the four-entry job queue has room
// for two jobs; the back end emits one output word per cycle while the output
// is not stalled, giving n words for a fragment of n characters and one for a
// report; the single byte-wide expansion unit sets this sustained rate.
module dictionary_text_decompressor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // code_byte
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // text_byte, status, total_length, pad
  output logic        m_axis_tuser,   // item_kind
  output logic        m_axis_tlast    // run_last
);

  logic          j0v, j1v, room2, qv, qpop;
  dtd_pkg::job_t j0, j1, qd;
  logic [7:0]    tb;
  logic [2:0]    st;
  logic [15:0]   tl;

  dtd_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .code_byte_i(s_axis_tdata), .message_end_i(s_axis_tlast),
    .job0_valid_o(j0v), .job0_o(j0), .job1_valid_o(j1v), .job1_o(j1),
    .q_room2_i(room2)
  );

  dtd_queue u_queue (
    .clk_i, .rst_ni, .wr0_i(j0v), .wd0_i(j0), .wr1_i(j1v), .wd1_i(j1),
    .room2_o(room2), .rd_valid_o(qv), .rd_data_o(qd), .rd_i(qpop)
  );

  dtd_back u_back (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_i(qd), .job_pop_o(qpop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .text_byte_o(tb), .item_kind_o(m_axis_tuser), .run_last_o(m_axis_tlast),
    .status_o(st), .total_length_o(tl)
  );

  assign m_axis_tdata = {5'd0, tl, st, tb};

endmodule
